// ----- design/upi_pkg.sv -----
// shared widths, codes, constants and the arctangent table of the pose integrator
`default_nettype none

package upi_pkg;

  // field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned SPEED_W = 24;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned ANGLE_W = 32;
  localparam int unsigned DT_W    = 16;

  // command codes
  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET_VEL  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SET_POSE = 2'd2;

  // register port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-3:0] REG_TICK_PERIOD = 1'b0;
  localparam logic [DT_W-1:0] TICK_PERIOD_RESET = 16'd655;

  // rotation unit
  localparam int unsigned TRIG_W       = 33;
  localparam int unsigned STEP_W       = 5;
  localparam int unsigned CORDIC_STEPS = 20;
  localparam logic signed [TRIG_W-1:0] CORDIC_START = 33'sd652032874;
  localparam logic [ANGLE_W-1:0] EIGHTH_TURN = 32'd536870912;

  // digit-serial multiplier
  localparam int unsigned MUL_A_W     = 42;
  localparam int unsigned MUL_B_W     = 24;
  localparam int unsigned MUL_DIGIT_W = 4;
  localparam int unsigned MUL_DIGITS  = MUL_B_W / MUL_DIGIT_W;
  localparam int unsigned MUL_CNT_W   = 3;
  localparam int unsigned MUL_P_W     = MUL_A_W + 1 + MUL_B_W;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic signed [ANGLE_W-1:0] atan_turn(input logic [STEP_W-1:0] idx);
    logic signed [ANGLE_W-1:0] val;
    begin
      case (idx)
        5'd0:    val = 32'sd536870912;
        5'd1:    val = 32'sd316933405;
        5'd2:    val = 32'sd167458907;
        5'd3:    val = 32'sd85004756;
        5'd4:    val = 32'sd42667331;
        5'd5:    val = 32'sd21354465;
        5'd6:    val = 32'sd10679838;
        5'd7:    val = 32'sd5340245;
        5'd8:    val = 32'sd2670163;
        5'd9:    val = 32'sd1335086;
        5'd10:   val = 32'sd667544;
        5'd11:   val = 32'sd333772;
        5'd12:   val = 32'sd166886;
        5'd13:   val = 32'sd83443;
        5'd14:   val = 32'sd41721;
        5'd15:   val = 32'sd20860;
        5'd16:   val = 32'sd10430;
        5'd17:   val = 32'sd5215;
        5'd18:   val = 32'sd2607;
        5'd19:   val = 32'sd1303;
        default: val = '0;
      endcase
      return val;
    end
  endfunction

endpackage

`default_nettype wire

// ----- design/upi_if.sv -----
// command and result channel interfaces of the pose integrator
`default_nettype none

interface upi_cmd_if;
  import upi_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic signed [SPEED_W-1:0] linear_speed;
  logic signed [SPEED_W-1:0] angular_speed;
  logic signed [POS_W-1:0]   pose_x;
  logic signed [POS_W-1:0]   pose_y;
  logic [ANGLE_W-1:0]        pose_heading;

  modport source (
    output valid, command, linear_speed, angular_speed, pose_x, pose_y, pose_heading,
    input  ready
  );
  modport sink (
    input  valid, command, linear_speed, angular_speed, pose_x, pose_y, pose_heading,
    output ready
  );
endinterface

interface upi_res_if;
  import upi_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [POS_W-1:0]   position_x;
  logic signed [POS_W-1:0]   position_y;
  logic [ANGLE_W-1:0]        heading;
  logic signed [SPEED_W-1:0] current_linear_speed;
  logic signed [SPEED_W-1:0] current_angular_speed;

  modport source (
    output valid, position_x, position_y, heading, current_linear_speed,
           current_angular_speed,
    input  ready
  );
  modport sink (
    input  valid, position_x, position_y, heading, current_linear_speed,
           current_angular_speed,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/upi_mul.sv -----
// radix-16 digit-serial signed multiplier, one multiplier digit per cycle
`default_nettype none

module upi_mul (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [upi_pkg::MUL_A_W-1:0]   mcand_i,
  input  logic signed [upi_pkg::MUL_B_W-1:0]   mplier_i,
  output logic                                 done_o,
  output logic signed [upi_pkg::MUL_P_W-1:0]   product_o
);
  import upi_pkg::*;

  localparam int unsigned SUM_W = MUL_A_W + MUL_DIGIT_W + 1;

  logic signed [MUL_A_W-1:0]  a_q;
  logic [MUL_B_W-1:0]         b_q, b_d;
  logic signed [MUL_A_W:0]    hi_q, hi_d;
  logic [MUL_B_W-1:0]         lo_q, lo_d;
  logic [MUL_CNT_W-1:0]       cnt_q;
  logic                       run_q, done_q;
  logic                       last;
  logic signed [MUL_DIGIT_W:0] digit;
  logic signed [SUM_W-1:0]    pp, sum;

  // top digit of the multiplier carries the sign, the others are unsigned
  assign last  = (cnt_q == MUL_CNT_W'(MUL_DIGITS - 1));
  assign digit = {b_q[MUL_DIGIT_W-1] & last, b_q[MUL_DIGIT_W-1:0]};
  assign pp    = $signed({{(SUM_W-MUL_A_W){a_q[MUL_A_W-1]}}, a_q})
               * $signed({{(SUM_W-MUL_DIGIT_W-1){digit[MUL_DIGIT_W]}}, digit});
  assign sum   = $signed({{(SUM_W-MUL_A_W-1){hi_q[MUL_A_W]}}, hi_q}) + pp;

  // accumulate and shift the low digit out into the low word
  assign hi_d = sum[SUM_W-1:MUL_DIGIT_W];
  assign lo_d = {sum[MUL_DIGIT_W-1:0], lo_q[MUL_B_W-1:MUL_DIGIT_W]};
  assign b_d  = {{MUL_DIGIT_W{1'b0}}, b_q[MUL_B_W-1:MUL_DIGIT_W]};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= mcand_i;
      b_q  <= mplier_i;
      hi_q <= '0;
      lo_q <= '0;
    end else if (run_q) begin
      b_q  <= b_d;
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign done_o    = done_q;
  assign product_o = {hi_q, lo_q};

endmodule

`default_nettype wire

// ----- design/upi_cordic.sv -----
// iterative rotation-mode cordic, one micro-rotation per cycle, quadrant folded
`default_nettype none

module upi_cordic (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [upi_pkg::ANGLE_W-1:0]         angle_i,
  output logic                                done_o,
  output logic signed [upi_pkg::TRIG_W-1:0]   cos_o,
  output logic signed [upi_pkg::TRIG_W-1:0]   sin_o
);
  import upi_pkg::*;

  logic signed [TRIG_W-1:0]  x_q, y_q, xs, ys;
  logic signed [ANGLE_W-1:0] z_q;
  logic [1:0]                quad_q;
  logic [STEP_W-1:0]         idx_q;
  logic                      run_q, done_q;
  logic [ANGLE_W-1:0]        shifted;
  logic                      last;

  assign shifted = angle_i + EIGHTH_TURN;
  assign last    = (idx_q == STEP_W'(CORDIC_STEPS - 1));
  assign xs      = x_q >>> idx_q;
  assign ys      = y_q >>> idx_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        idx_q <= '0;
      end else if (run_q) begin
        idx_q <= idx_q + 1'b1;
        if (last) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // micro-rotation toward zero residual angle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quad_q <= shifted[ANGLE_W-1:ANGLE_W-2];
      z_q    <= $signed({2'b00, shifted[ANGLE_W-3:0]}) - $signed(EIGHTH_TURN);
      x_q    <= CORDIC_START;
      y_q    <= '0;
    end else if (run_q) begin
      if (!z_q[ANGLE_W-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_turn(idx_q);
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_turn(idx_q);
      end
    end
  end

  // unfold the quadrant
  always_comb begin
    case (quad_q)
      2'd0: begin
        cos_o = x_q;
        sin_o = y_q;
      end
      2'd1: begin
        cos_o = -y_q;
        sin_o = x_q;
      end
      2'd2: begin
        cos_o = -x_q;
        sin_o = -y_q;
      end
      default: begin
        cos_o = y_q;
        sin_o = -x_q;
      end
    endcase
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

// ----- design/unicycle_pose_integrator.sv -----
// top level of the unicycle dead-reckoning pose integrator
`default_nettype none

// channel   dir  handshake            carries
// cmd_i     in   valid / ready        command, speeds, pose to load
// res_o     out  valid / ready        pose and stored speeds after a tick
// apb       in   psel/penable/pready  tick_period at byte address 0
//
// set velocity, set pose and the unused command keep the block idle and ready.
// a tick runs 6 digit steps for the heading product, 20 cordic steps, then 6 + 6 digit
// steps for speed times trig and times the tick period, with x and y on two multipliers
// side by side; handoffs write the heading, start the multipliers, write the position and
// write the result out, and the block then takes the next item. the result sits in an
// output register, so a stalled result only holds the next tick at its final write-out.
// reset clears the pose, speeds and result valid.

module unicycle_pose_integrator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  upi_cmd_if.sink                            cmd_i,
  upi_res_if.source                          res_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [upi_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [upi_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [upi_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import upi_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HEAD = 3'd1;
  localparam logic [2:0] S_ROT  = 3'd2;
  localparam logic [2:0] S_VEL  = 3'd3;
  localparam logic [2:0] S_STEP = 3'd4;
  localparam logic [2:0] S_PUT  = 3'd5;

  logic [2:0]                state_q, state_d;
  logic [DT_W-1:0]           tick_period_q;
  logic signed [POS_W-1:0]   pos_x_q, pos_y_q;
  logic [ANGLE_W-1:0]        heading_q, head_next;
  logic signed [SPEED_W-1:0] speed_lin_q, speed_ang_q;

  logic                      res_valid_q;
  logic signed [POS_W-1:0]   out_x_q, out_y_q;
  logic [ANGLE_W-1:0]        out_head_q;
  logic signed [SPEED_W-1:0] out_lin_q, out_ang_q;

  logic                      cmd_acc, cfg_wr, put_ok;
  logic                      start_x, start_y, start_rot;
  logic                      done_x, done_y, rot_done;
  logic signed [MUL_A_W-1:0] mul_a_x, mul_a_y;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod_x, prod_y;
  logic signed [TRIG_W-1:0]  cos_v, sin_v;
  logic signed [MUL_P_W-1:0] rnd_x, rnd_y;
  logic signed [MUL_A_W-1:0] q_x, q_y;
  logic signed [MUL_B_W-1:0] dt_ext;

  // round the move to 2^-16 m and add it to the position with saturation
  function automatic logic [POS_W-1:0] step_pos(input logic [POS_W-1:0] pos,
                                                input logic signed [MUL_P_W-1:0] prod);
    logic signed [MUL_P_W-1:0] rnd;
    logic [POS_W:0]            delta;
    logic [POS_W+1:0]          sum;
    logic [POS_W-1:0]          res;
    begin
      rnd   = prod + MUL_P_W'(134217728);
      delta = rnd[POS_W+28:28];
      sum   = {{2{pos[POS_W-1]}}, pos} + {delta[POS_W], delta};
      if (sum[POS_W+1:POS_W-1] == 3'b000 || sum[POS_W+1:POS_W-1] == 3'b111) begin
        res = sum[POS_W-1:0];
      end else if (sum[POS_W+1]) begin
        res = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
        res = {1'b0, {(POS_W-1){1'b1}}};
      end
      return res;
    end
  endfunction

  // handshakes
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;
  assign cmd_i.ready = (state_q == S_IDLE);
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign put_ok      = !res_valid_q || res_o.ready;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[APB_ADDR_W-1:2] == REG_TICK_PERIOD)
                ? {{(APB_DATA_W-DT_W){1'b0}}, tick_period_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_period_q <= TICK_PERIOD_RESET;
    end else if (cfg_wr && paddr[APB_ADDR_W-1:2] == REG_TICK_PERIOD) begin
      tick_period_q <= pwdata[DT_W-1:0];
    end
  end

  // arithmetic glue between the units
  assign dt_ext    = {{(MUL_B_W-DT_W){1'b0}}, tick_period_q};
  assign head_next = heading_q + prod_x[ANGLE_W-1:0];
  assign rnd_x     = prod_x + MUL_P_W'(8192);
  assign rnd_y     = prod_y + MUL_P_W'(8192);
  assign q_x       = rnd_x[MUL_A_W+13:14];
  assign q_y       = rnd_y[MUL_A_W+13:14];

  // sequencer, x and y multipliers run in lockstep for the position products
  always_comb begin
    state_d   = state_q;
    start_x   = 1'b0;
    start_y   = 1'b0;
    start_rot = 1'b0;
    mul_a_x   = '0;
    mul_a_y   = '0;
    mul_b     = dt_ext;
    unique case (state_q)
      S_IDLE: begin
        mul_a_x = {{(MUL_A_W-SPEED_W){speed_ang_q[SPEED_W-1]}}, speed_ang_q};
        if (cmd_acc && cmd_i.command == CMD_TICK) begin
          start_x = 1'b1;
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        if (done_x) begin
          start_rot = 1'b1;
          state_d   = S_ROT;
        end
      end
      S_ROT: begin
        mul_a_x = {{(MUL_A_W-TRIG_W){cos_v[TRIG_W-1]}}, cos_v};
        mul_a_y = {{(MUL_A_W-TRIG_W){sin_v[TRIG_W-1]}}, sin_v};
        mul_b   = speed_lin_q;
        if (rot_done) begin
          start_x = 1'b1;
          start_y = 1'b1;
          state_d = S_VEL;
        end
      end
      S_VEL: begin
        mul_a_x = q_x;
        mul_a_y = q_y;
        if (done_x && done_y) begin
          start_x = 1'b1;
          start_y = 1'b1;
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        if (done_x && done_y) begin
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        if (put_ok) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // pose and speed state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      heading_q   <= '0;
      speed_lin_q <= '0;
      speed_ang_q <= '0;
    end else begin
      state_q <= state_d;
      if (cmd_acc) begin
        case (cmd_i.command)
          CMD_SET_VEL: begin
            speed_lin_q <= cmd_i.linear_speed;
            speed_ang_q <= cmd_i.angular_speed;
          end
          CMD_SET_POSE: begin
            pos_x_q     <= cmd_i.pose_x;
            pos_y_q     <= cmd_i.pose_y;
            heading_q   <= cmd_i.pose_heading;
            speed_lin_q <= '0;
            speed_ang_q <= '0;
          end
          default: ;
        endcase
      end
      if (state_q == S_HEAD && done_x) begin
        heading_q <= head_next;
      end
      if (state_q == S_STEP && done_x && done_y) begin
        pos_x_q <= step_pos(pos_x_q, prod_x);
        pos_y_q <= step_pos(pos_y_q, prod_y);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (state_q == S_PUT && put_ok) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_PUT && put_ok) begin
      out_x_q    <= pos_x_q;
      out_y_q    <= pos_y_q;
      out_head_q <= heading_q;
      out_lin_q  <= speed_lin_q;
      out_ang_q  <= speed_ang_q;
    end
  end

  assign res_o.valid                 = res_valid_q;
  assign res_o.position_x            = out_x_q;
  assign res_o.position_y            = out_y_q;
  assign res_o.heading               = out_head_q;
  assign res_o.current_linear_speed  = out_lin_q;
  assign res_o.current_angular_speed = out_ang_q;

  // units
  upi_mul u_mul_x (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_x),
    .mcand_i   (mul_a_x),
    .mplier_i  (mul_b),
    .done_o    (done_x),
    .product_o (prod_x)
  );

  upi_mul u_mul_y (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_y),
    .mcand_i   (mul_a_y),
    .mplier_i  (mul_b),
    .done_o    (done_y),
    .product_o (prod_y)
  );

  upi_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_rot),
    .angle_i (head_next),
    .done_o  (rot_done),
    .cos_o   (cos_v),
    .sin_o   (sin_v)
  );

endmodule

`default_nettype wire

// ----- design/upi_chk.sv -----
// port-level checks of the pose integrator and their bind
`default_nettype none

module upi_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               cmd_valid_i,
  input logic                               cmd_ready_i,
  input logic [upi_pkg::CMD_W-1:0]          command_i,
  input logic                               res_valid_i,
  input logic                               res_ready_i,
  input logic [upi_pkg::POS_W-1:0]          res_x_i,
  input logic [upi_pkg::ANGLE_W-1:0]        res_head_i,
  input logic                               psel_i,
  input logic                               penable_i,
  input logic                               pwrite_i,
  input logic [upi_pkg::APB_ADDR_W-1:0]     paddr_i,
  input logic [upi_pkg::APB_DATA_W-1:0]     pwdata_i,
  input logic [upi_pkg::APB_DATA_W-1:0]     prdata_i
);
  import upi_pkg::*;

  logic cmd_acc;
  assign cmd_acc = cmd_valid_i && cmd_ready_i;

  // a tick item occupies the block
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_acc && command_i == CMD_TICK |=> !cmd_ready_i)
    else $error("ready stayed high after a tick item");

  // loads and the unused command leave the block ready
  a_load_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_acc && command_i != CMD_TICK |=> cmd_ready_i)
    else $error("block busy after a one-cycle item");

  // a result only comes out of tick work
  a_res_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(!cmd_ready_i))
    else $error("result appeared without tick work");

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_x_i) && $stable(res_head_i))
    else $error("stalled result changed");

  // tick period reads back what was written
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel_i && penable_i && pwrite_i && paddr_i[APB_ADDR_W-1:2] == REG_TICK_PERIOD
    |=> paddr_i[APB_ADDR_W-1:2] != REG_TICK_PERIOD
        || prdata_i == {{(APB_DATA_W-DT_W){1'b0}}, $past(pwdata_i[DT_W-1:0])})
    else $error("tick period readback mismatch");

endmodule

bind unicycle_pose_integrator upi_chk u_upi_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cmd_valid_i (cmd_i.valid),
  .cmd_ready_i (cmd_i.ready),
  .command_i   (cmd_i.command),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_x_i     (res_o.position_x),
  .res_head_i  (res_o.heading),
  .psel_i      (psel),
  .penable_i   (penable),
  .pwrite_i    (pwrite),
  .paddr_i     (paddr),
  .pwdata_i    (pwdata),
  .prdata_i    (prdata)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// self-checking testbench of the unicycle pose integrator: table-driven and random items
`timescale 1ns / 1ps

module tb_top;
  import upi_pkg::*;

  // command code that the block ignores
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [APB_ADDR_W-1:0] TICK_PERIOD_ADDR = {REG_TICK_PERIOD, 2'b00};

  localparam logic signed [SPEED_W-1:0] SPEED_MAX = 24'sh7FFFFF;
  localparam logic signed [SPEED_W-1:0] SPEED_MIN = 24'sh800000;
  localparam logic signed [POS_W-1:0]   POS_MAX   = 32'sh7FFFFFFF;
  localparam logic signed [POS_W-1:0]   POS_MIN   = 32'sh80000000;
  localparam longint POS_MAX_L = 64'sd2147483647;
  localparam longint POS_MIN_L = -64'sd2147483648;

  localparam int SETTLE_CYCLES  = 100;
  localparam int HOLD_CYCLES    = 600;
  localparam int PHASE_ITEMS    = 150;
  localparam int RANDOM_PHASES  = 6;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic signed [SPEED_W-1:0] linear_speed;
    logic signed [SPEED_W-1:0] angular_speed;
    logic signed [POS_W-1:0]   pose_x;
    logic signed [POS_W-1:0]   pose_y;
    logic [ANGLE_W-1:0]        pose_heading;
  } cmd_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0]   position_x;
    logic signed [POS_W-1:0]   position_y;
    logic [ANGLE_W-1:0]        heading;
    logic signed [SPEED_W-1:0] linear_speed;
    logic signed [SPEED_W-1:0] angular_speed;
  } pose_t;

  typedef enum logic {ROW_ITEM, ROW_PERIOD} row_kind_e;

  typedef struct {
    row_kind_e       kind;
    logic [DT_W-1:0] period;
    cmd_item_t       item;
    bit              checked;
    pose_t           want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  upi_cmd_if cmd_bus ();
  upi_res_if res_bus ();

  unicycle_pose_integrator dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_bus),
    .res_o   (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // predicted state of the integrator
  logic [DT_W-1:0]           dt_reg;
  logic signed [POS_W-1:0]   est_x;
  logic signed [POS_W-1:0]   est_y;
  logic [ANGLE_W-1:0]        est_heading;
  logic signed [SPEED_W-1:0] est_lin;
  logic signed [SPEED_W-1:0] est_ang;

  pose_t    pending_poses[$];
  dir_row_t dir_rows[$];
  int       err_count = 0;
  int       send_idle_pct;
  int       recv_idle_pct;
  bit       hold_armed = 1'b0;
  bit       hold_done = 1'b0;

  // arctangent of 2^-i in units of 2^-32 turn
  longint atan_steps [0:CORDIC_STEPS-1] = '{
    536870912, 316933405, 167458907, 85004756, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335086,
    667544, 333772, 166886, 83443, 41721,
    20860, 10430, 5215, 2607, 1303
  };

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // cosine and sine in q1.30: fold to one quadrant, then rotate the residual angle
  function automatic void rotate(input logic [ANGLE_W-1:0] angle, output longint cos_v,
                                 output longint sin_v);
    logic [ANGLE_W-1:0] a;
    longint x, y, z, xs, ys;
    a = angle + EIGHTH_TURN;
    z = longint'(a[29:0]) - longint'(EIGHTH_TURN);
    x = longint'(CORDIC_START);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - atan_steps[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + atan_steps[i];
      end
    end
    case (a[31:30])
      2'd0: begin cos_v = x;  sin_v = y;  end
      2'd1: begin cos_v = -y; sin_v = x;  end
      2'd2: begin cos_v = -x; sin_v = -y; end
      default: begin cos_v = y; sin_v = -x; end
    endcase
  endfunction

  function automatic longint round_half_up(input longint v, input int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  // one axis step: trig * speed * dt, rounded twice, saturating sum
  function automatic logic signed [POS_W-1:0] move_axis(input logic signed [POS_W-1:0] pos,
                                                        input longint trig, input longint v,
                                                        input longint dt);
    longint q, delta, sum;
    q     = round_half_up(trig * v, 14);
    delta = round_half_up(q * dt, 28);
    sum   = longint'(pos) + delta;
    if (sum > POS_MAX_L) return POS_MAX;
    if (sum < POS_MIN_L) return POS_MIN;
    return sum[31:0];
  endfunction

  // advance the predicted state by one item; returns 1 when the item emits a pose
  function automatic bit integrate_cmd(input cmd_item_t c, output pose_t r);
    longint dt, turn, cos_v, sin_v;
    r = '0;
    case (c.command)
      CMD_SET_VEL: begin
        est_lin = c.linear_speed;
        est_ang = c.angular_speed;
        return 1'b0;
      end
      CMD_SET_POSE: begin
        est_x       = c.pose_x;
        est_y       = c.pose_y;
        est_heading = c.pose_heading;
        est_lin     = '0;
        est_ang     = '0;
        return 1'b0;
      end
      CMD_TICK: begin
        dt          = longint'(dt_reg);
        turn        = longint'(est_ang) * dt;
        est_heading = est_heading + turn[31:0];
        rotate(est_heading, cos_v, sin_v);
        est_x = move_axis(est_x, cos_v, longint'(est_lin), dt);
        est_y = move_axis(est_y, sin_v, longint'(est_lin), dt);
        r = '{est_x, est_y, est_heading, est_lin, est_ang};
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic cmd_item_t mk_cmd(input logic [CMD_W-1:0] c, input logic [SPEED_W-1:0] l,
                                       input logic [SPEED_W-1:0] a, input logic [POS_W-1:0] x,
                                       input logic [POS_W-1:0] y, input logic [ANGLE_W-1:0] h);
    return '{c, l, a, x, y, h};
  endfunction

  function automatic pose_t mk_pose(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                    input logic [ANGLE_W-1:0] h, input logic [SPEED_W-1:0] l,
                                    input logic [SPEED_W-1:0] a);
    return '{x, y, h, l, a};
  endfunction

  function automatic void add_item(input cmd_item_t c);
    dir_rows.push_back('{ROW_ITEM, '0, c, 1'b0, '0});
  endfunction

  function automatic void add_check(input cmd_item_t c, input pose_t want);
    dir_rows.push_back('{ROW_ITEM, '0, c, 1'b1, want});
  endfunction

  function automatic void add_period(input logic [DT_W-1:0] p);
    dir_rows.push_back('{ROW_PERIOD, p, '0, 1'b0, '0});
  endfunction

  // speeds: full range, extremes or small values
  function automatic logic [SPEED_W-1:0] random_speed();
    int v;
    case ($urandom_range(3))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(3))
          0: return SPEED_MAX;
          1: return SPEED_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      default: begin
        v = $urandom_range(8191);
        return v - 4096;
      end
    endcase
  endfunction

  // positions: full range, close to the saturation bounds, or near the origin
  function automatic logic [POS_W-1:0] random_pos();
    logic [15:0] low;
    int v;
    low = $urandom;
    case ($urandom_range(3))
      0, 1: return $urandom;
      2: begin
        if ($urandom_range(1)) return {16'h7FFF, low};
        return {16'h8000, low};
      end
      default: begin
        v = $urandom_range(2097151);
        return v - 1048576;
      end
    endcase
  endfunction

  // headings: mostly any angle, sometimes right around a quadrant boundary
  function automatic logic [ANGLE_W-1:0] random_heading();
    logic [1:0] quad;
    logic [ANGLE_W-1:0] off;
    if ($urandom_range(3) != 0) return $urandom;
    quad = $urandom_range(3);
    off  = $urandom_range(15);
    return {quad, 30'd0} + off - 32'd8;
  endfunction

  function automatic cmd_item_t random_cmd();
    cmd_item_t c;
    int unsigned pick;
    c.linear_speed  = random_speed();
    c.angular_speed = random_speed();
    c.pose_x        = random_pos();
    c.pose_y        = random_pos();
    c.pose_heading  = random_heading();
    pick = $urandom_range(99);
    if (pick < 55) c.command = CMD_TICK;
    else if (pick < 75) c.command = CMD_SET_VEL;
    else if (pick < 93) c.command = CMD_SET_POSE;
    else c.command = CMD_UNUSED;
    return c;
  endfunction

  // offer one item; caller and return are at a falling edge
  task automatic send_cmd(input cmd_item_t c, input bit checked, input pose_t want);
    pose_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_bus.valid         <= 1'b1;
    cmd_bus.command       <= c.command;
    cmd_bus.linear_speed  <= c.linear_speed;
    cmd_bus.angular_speed <= c.angular_speed;
    cmd_bus.pose_x        <= c.pose_x;
    cmd_bus.pose_y        <= c.pose_y;
    cmd_bus.pose_heading  <= c.pose_heading;
    do @(posedge clk_i); while (!cmd_bus.ready);
    if (integrate_cmd(c, r)) pending_poses.push_back(checked ? want : r);
    @(negedge clk_i);
  endtask

  // stop offering, wait for every pending pose, then let the block settle
  task automatic drain();
    cmd_bus.valid <= 1'b0;
    while (pending_poses.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // apb write of the tick period followed by a read-back
  task automatic write_tick_period(input logic [DT_W-1:0] value);
    logic [APB_DATA_W-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TICK_PERIOD_ADDR;
    pwdata  <= APB_DATA_W'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[DT_W-1:0] !== value) report_mismatch("tick_period read-back", rd, value);
    dt_reg = value;
  endtask

  // compare each accepted pose with the oldest pending one
  always @(posedge clk_i) begin : pose_check
    pose_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (pending_poses.size() == 0) begin
        report_mismatch("pose with none pending", res_bus.position_x, '0);
      end else begin
        want = pending_poses.pop_front();
        if (res_bus.position_x !== want.position_x)
          report_mismatch("position_x", res_bus.position_x, want.position_x);
        if (res_bus.position_y !== want.position_y)
          report_mismatch("position_y", res_bus.position_y, want.position_y);
        if (res_bus.heading !== want.heading)
          report_mismatch("heading", res_bus.heading, want.heading);
        if (res_bus.current_linear_speed !== want.linear_speed)
          report_mismatch("current_linear_speed", res_bus.current_linear_speed,
                          want.linear_speed);
        if (res_bus.current_angular_speed !== want.angular_speed)
          report_mismatch("current_angular_speed", res_bus.current_angular_speed,
                          want.angular_speed);
      end
    end
  end

  // result side: random stalls plus one long hold-off
  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_armed && !hold_done) begin
        res_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
      end
      res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // run limit
  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

  // stimulus
  initial begin
    logic [DT_W-1:0] phase_period [RANDOM_PHASES];
    cmd_item_t c;
    int sent;

    cmd_bus.valid         = 1'b0;
    cmd_bus.command       = CMD_TICK;
    cmd_bus.linear_speed  = '0;
    cmd_bus.angular_speed = '0;
    cmd_bus.pose_x        = '0;
    cmd_bus.pose_y        = '0;
    cmd_bus.pose_heading  = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    rst_ni  = 1'b0;
    send_idle_pct = 18;
    recv_idle_pct = 57;

    dt_reg      = TICK_PERIOD_RESET;
    est_x       = '0;
    est_y       = '0;
    est_heading = '0;
    est_lin     = '0;
    est_ang     = '0;

    // after reset a tick leaves everything at zero
    add_check(mk_cmd(CMD_TICK, 0, 0, 0, 0, 0), mk_pose(0, 0, 0, 0, 0));
    add_item(mk_cmd(CMD_SET_VEL, SPEED_MAX, SPEED_MIN, 0, 0, 0));
    add_item(mk_cmd(CMD_TICK, '1, '1, '1, '1, '1));
    add_item(mk_cmd(CMD_TICK, 0, 0, 0, 0, 0));
    add_item(mk_cmd(CMD_SET_VEL, SPEED_MIN, SPEED_MAX, '1, '1, '1));
    add_item(mk_cmd(CMD_TICK, 0, 0, 0, 0, 0));
    // unused command changes nothing
    add_item(mk_cmd(CMD_UNUSED, '1, '1, '1, '1, '1));
    add_item(mk_cmd(CMD_TICK, 0, 0, 0, 0, 0));
    // set pose clears the speeds
    add_item(mk_cmd(CMD_SET_POSE, '1, '1, POS_MAX, POS_MIN, 32'hFFFF_FFFF));
    add_check(mk_cmd(CMD_TICK, 0, 0, 0, 0, 0),
              mk_pose(POS_MAX, POS_MIN, 32'hFFFF_FFFF, 0, 0));
    add_item(mk_cmd(CMD_SET_VEL, SPEED_MAX, 0, 0, 0, 0));
    add_item(mk_cmd(CMD_TICK, 0, 0, 0, 0, 0));
    // longest step, one tick from each of three quadrant boundaries
    add_period(16'hFFFF);
    add_item(mk_cmd(CMD_SET_POSE, 0, 0, 0, 0, 32'h4000_0000));
    add_item(mk_cmd(CMD_SET_VEL, SPEED_MIN, 0, 0, 0, 0));
    add_item(mk_cmd(CMD_TICK, 0, 0, 0, 0, 0));
    add_item(mk_cmd(CMD_SET_POSE, 0, 0, POS_MIN, POS_MAX, 32'h8000_0000));
    add_item(mk_cmd(CMD_SET_VEL, SPEED_MAX, 0, 0, 0, 0));
    add_item(mk_cmd(CMD_TICK, 0, 0, 0, 0, 0));
    add_item(mk_cmd(CMD_SET_POSE, 0, 0, 0, 0, 32'hC000_0000));
    add_item(mk_cmd(CMD_SET_VEL, SPEED_MAX, SPEED_MAX, 0, 0, 0));
    add_item(mk_cmd(CMD_TICK, 0, 0, 0, 0, 0));
    // zero step: the pose stays put
    add_period(16'd0);
    add_item(mk_cmd(CMD_SET_POSE, 0, 0, 32'sd12345678, -32'sd7654321, 32'h2000_0000));
    add_item(mk_cmd(CMD_SET_VEL, SPEED_MAX, SPEED_MAX, 0, 0, 0));
    add_check(mk_cmd(CMD_TICK, 0, 0, 0, 0, 0),
              mk_pose(32'sd12345678, -32'sd7654321, 32'h2000_0000, SPEED_MAX, SPEED_MAX));
    // shortest nonzero step
    add_period(16'd1);
    add_item(mk_cmd(CMD_TICK, 0, 0, 0, 0, 0));

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_PERIOD) begin
        drain();
        write_tick_period(dir_rows[i].period);
      end else begin
        send_cmd(dir_rows[i].item, dir_rows[i].checked, dir_rows[i].want);
      end
    end

    // random phases over several step sizes and idle patterns
    phase_period[0] = 16'hFFFF;
    phase_period[1] = 16'd1;
    phase_period[2] = TICK_PERIOD_RESET;
    for (int p = 3; p < RANDOM_PHASES; p++) phase_period[p] = $urandom_range(65535, 1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      write_tick_period(phase_period[p]);
      case (p / 2)
        0: begin send_idle_pct = 18; recv_idle_pct = 57; end
        1: begin send_idle_pct = 57; recv_idle_pct = 18; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      // sender keeps offering while the result side holds off
      if (p == 4) hold_armed = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        c = random_cmd();
        send_cmd(c, 1'b0, '0);
        if (c.command != CMD_UNUSED) sent++;
      end
    end

    drain();
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/upi_pkg.sv
design/upi_if.sv
design/upi_mul.sv
design/upi_cordic.sv
design/unicycle_pose_integrator.sv
design/upi_chk.sv
tb/tb_top.sv
